[hw/rtl/mts_pkg.sv]
`timescale 1ns / 1ps

package mts_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W     = 2 * VALUE_WIDTH;

  // in_mode codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_t;

  // controller -> datapath
  typedef struct packed {
    logic do_push;   // store new top, spill old top to RAM
    logic do_pop;    // drop top, fetch next one from RAM
    logic load_top;  // take RAM read data into top registers
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic one;
  } stat_t;

endpackage

[hw/rtl/mts_ram.sv]
`timescale 1ns / 1ps

module mts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mts_ctrl.sv]
`timescale 1ns / 1ps

module mts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_mode,
  input  mts_pkg::stat_t stat,
  output mts_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_valid,
  output mts_pkg::err_t  err
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  mts_pkg::err_t err_r, err_nxt;
  logic          accept;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          err_nxt   = mts_pkg::ERR_NONE;
          state_nxt = ST_OUT;
          if (in_mode == mts_pkg::MODE_PUSH) begin
            if (stat.full) begin
              err_nxt = mts_pkg::ERR_PUSH_FULL;
            end else begin
              cmd.do_push = 1'b1;
            end
          end else begin
            if (stat.empty) begin
              err_nxt = mts_pkg::ERR_POP_EMPTY;
            end else begin
              cmd.do_pop = 1'b1;
              // more than one entry: next top must come back from RAM
              if (!stat.one) begin
                state_nxt = ST_LOAD;
              end
            end
          end
        end
      end
      ST_LOAD: begin
        cmd.load_top = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      err_r   <= mts_pkg::ERR_NONE;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign err       = err_r;

endmodule

[hw/rtl/mts_dp.sv]
`timescale 1ns / 1ps

module mts_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mts_pkg::cmd_t                          cmd,
  input  logic signed [mts_pkg::VALUE_WIDTH-1:0] in_value,
  output mts_pkg::stat_t                         stat,
  output logic signed [mts_pkg::VALUE_WIDTH-1:0] top_value,
  output logic signed [mts_pkg::VALUE_WIDTH-1:0] max_value
);

  logic [mts_pkg::FILL_W-1:0]             fill_r, fill_nxt;
  logic signed [mts_pkg::VALUE_WIDTH-1:0] top_r, top_nxt;
  logic signed [mts_pkg::VALUE_WIDTH-1:0] max_r, max_nxt;
  logic [mts_pkg::FILL_W-1:0]             fill_m1, fill_m2;
  logic [mts_pkg::ENTRY_W-1:0]            rd_entry;
  logic                                   ram_we;

  assign fill_m1 = fill_r - mts_pkg::FILL_W'(1);
  assign fill_m2 = fill_r - mts_pkg::FILL_W'(2);

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == mts_pkg::FILL_W'(mts_pkg::STACK_DEPTH));
  assign stat.one   = (fill_r == mts_pkg::FILL_W'(1));

  // RAM holds every level below the top; the top lives in top_r / max_r
  assign ram_we = cmd.do_push && !stat.empty;

  mts_ram #(
    .WIDTH (mts_pkg::ENTRY_W),
    .DEPTH (mts_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_m1[mts_pkg::ADDR_W-1:0]),
    .wdata ({top_r, max_r}),
    .re    (cmd.do_pop),
    .raddr (fill_m2[mts_pkg::ADDR_W-1:0]),
    .rdata (rd_entry)
  );

  always_comb begin
    fill_nxt = fill_r;
    top_nxt  = top_r;
    max_nxt  = max_r;
    if (cmd.do_push) begin
      fill_nxt = fill_r + mts_pkg::FILL_W'(1);
      top_nxt  = in_value;
      // ties keep the old max
      if (stat.empty || (in_value > max_r)) begin
        max_nxt = in_value;
      end
    end
    if (cmd.do_pop) begin
      fill_nxt = fill_m1;
    end
    if (cmd.load_top) begin
      top_nxt = rd_entry[mts_pkg::ENTRY_W-1:mts_pkg::VALUE_WIDTH];
      max_nxt = rd_entry[mts_pkg::VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    max_r <= max_nxt;
  end

  assign top_value = stat.empty ? '0 : top_r;
  assign max_value = stat.empty ? '0 : max_r;

endmodule

[hw/rtl/max_tracking_stack_top.sv]
`timescale 1ns / 1ps

// LIFO stack of signed values that tracks the running maximum. Raise start
// with in_mode (0 push in_value, 1 pop) while busy is low; that edge takes
// the transaction. Exactly one result follows: out_valid is high for one
// cycle with the new top, the current maximum (both zero when empty), the
// empty flag and an error code (pop on empty, push on full; the stack is
// left unchanged in both cases). The receiver cannot stall, so sample the
// result ports whenever out_valid is high. For a push, a rejected
// transaction or a pop that leaves the stack empty, out_valid is high in
// the cycle right after the accepting edge; a pop that uncovers a stored
// level first passes through a load state, because the new top must be
// read from the stack RAM, whose read port is registered. busy stays high
// from the accepting edge through the result cycle, so a new transaction
// is taken only after the result of the last one. No clearing pass is
// needed after reset: only levels below the fill count are ever read.
module max_tracking_stack_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_mode,
  input  logic signed [mts_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                   out_valid,
  output logic signed [mts_pkg::VALUE_WIDTH-1:0] out_top_value,
  output logic signed [mts_pkg::VALUE_WIDTH-1:0] out_max_value,
  output logic                                   out_is_empty,
  output logic [1:0]                             out_error
);

  mts_pkg::cmd_t  cmd;
  mts_pkg::stat_t stat;
  mts_pkg::err_t  err;

  // sequencer: accept, optional RAM fetch, result strobe
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .err       (err)
  );

  // top registers, fill count and the RAM for lower levels
  mts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_value),
    .stat      (stat),
    .top_value (out_top_value),
    .max_value (out_max_value)
  );

  assign out_is_empty = stat.empty;
  assign out_error    = err;

`ifndef SYNTHESIS
  // one strobe per transaction
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // an accepted transaction keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // a rejected pop always reports an empty stack
  a_pop_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error == mts_pkg::ERR_POP_EMPTY)) |-> out_is_empty)
    else $error("pop-on-empty error without empty flag");

  // the tracked maximum never falls below the top value
  a_max_ge_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_empty) |-> (out_max_value >= out_top_value))
    else $error("maximum below top value");
`endif

endmodule
